### rtl/crsp_pkg.sv
// ----------------------------------------------------------------------------
// crsp_pkg
// Shared widths and constants for the cable robot step planner.
// ----------------------------------------------------------------------------
package crsp_pkg;
   localparam int COORD_W    = 18;
   localparam int CFG_DIM_W  = 17;
   localparam int SPM_W      = 24;
   localparam int STEP_W     = 21;
   localparam int NUM_CABLES = 4;
   localparam int COORD_FRAC = 4;
   localparam int LEN_FRAC   = 12;
   localparam int SPM_FRAC   = 16;
   localparam int RAD_W      = 64;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int ACC_W      = 2 * COORD_W + 2;
   localparam int RAD_SHIFT  = 2 * (LEN_FRAC - COORD_FRAC);
   localparam int MUL_A_W    = ROOT_W;
   localparam int MUL_B_W    = SPM_W;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int SCALE_SH   = LEN_FRAC + SPM_FRAC;
   localparam int MAG_W      = PROD_W - SCALE_SH;

   localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
   localparam logic [1:0] REG_FRAME_DEPTH   = 2'd1;
   localparam logic [1:0] REG_PULLEY_HEIGHT = 2'd2;
   localparam logic [1:0] REG_STEPS_PER_MM  = 2'd3;

   localparam logic REQ_SET  = 1'b0;
   localparam logic REQ_MOVE = 1'b1;

   localparam logic [MAG_W-1:0] STEP_MAX_MAG = MAG_W'(1048575);
   localparam logic [MAG_W-1:0] STEP_MIN_MAG = MAG_W'(1048576);
endpackage

### rtl/crsp_isqrt.sv
// ----------------------------------------------------------------------------
// crsp_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module crsp_isqrt
   import crsp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);
   localparam int CNT_W = $clog2(ROOT_W);

   logic [RAD_W-1:0] rem_ff, rem_in;
   logic [RAD_W-1:0] root_ff, root_in;
   logic [RAD_W-1:0] bit_ff, bit_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [RAD_W-1:0] trial;

   assign trial = root_ff + bit_ff;

   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = radicand;
         root_in = '0;
         bit_in  = {2'b01, {(RAD_W-2){1'b0}}};
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign done = done_ff;
   assign root = root_ff[ROOT_W-1:0];
endmodule

### rtl/cable_robot_step_planner.sv
// ----------------------------------------------------------------------------
// A move runs eight square roots, two per cable, one after another in the shared root unit.
// Throughput: one request at a time; req_tready stays low until the result
// word is taken. A set request updates the position in S_IDLE and yields no word.
// Reset: synchronous; registers load their defaults and position clears to 0.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// cable_robot_step_planner
// Four-cable robot inverse kinematics: per-cable step counts for a move.
// ----------------------------------------------------------------------------
module cable_robot_step_planner
   import crsp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [55:0]       req_tdata,   // pos_x, pos_y, pos_z, zero pad
   input  logic              req_tuser,   // req_type
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [87:0]       rsp_tdata,   // steps_cable1..4, saturated, zero pad
   input  logic              csr_we,
   input  logic [1:0]        csr_addr,
   input  logic [SPM_W-1:0]  csr_wdata
);
   typedef enum logic [3:0] {
      S_IDLE, S_SQ_OP, S_SQ_MUL, S_SQ_ACC, S_RT_START, S_RT_WAIT,
      S_SC_OP, S_SC_MUL, S_SC_ACC, S_OUT
   } state_type;

   state_type state_ff;

   logic [CFG_DIM_W-1:0] width_ff, depth_ff, height_ff;
   logic [SPM_W-1:0]     spm_ff;
   logic signed [COORD_W-1:0] cur_ff [3];
   logic signed [COORD_W-1:0] new_ff [3];
   logic [1:0]           cable_ff;
   logic                 pass_ff;
   logic [1:0]           axis_ff;
   logic [ACC_W-1:0]     acc_ff;
   logic [ROOT_W-1:0]    len_old_ff, len_new_ff;
   logic [MUL_A_W-1:0]   mul_a_ff;
   logic [MUL_B_W-1:0]   mul_b_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [STEP_W-1:0]    step_ff [NUM_CABLES];
   logic                 sat_ff;

   logic signed [COORD_W-1:0] pos_sel;
   logic signed [DIFF_W-1:0]  pul_sel, diff;
   logic [DIFF_W-1:0]         diff_abs;
   logic                      rt_start, rt_done;
   logic [ROOT_W-1:0]         rt_root;
   logic [RAD_W-1:0]          radicand;
   logic                      reel_in;
   logic [ROOT_W-1:0]         delta;
   logic [MAG_W-1:0]          mag;

   // pulley coordinate of the current cable and axis
   always_comb begin
      case (axis_ff)
         2'd0: pul_sel = (cable_ff == 2'd2 || cable_ff == 2'd3) ?
                         DIFF_W'(width_ff) : '0;
         2'd1: pul_sel = (cable_ff == 2'd1 || cable_ff == 2'd2) ?
                         DIFF_W'(depth_ff) : '0;
         default: pul_sel = DIFF_W'(height_ff);
      endcase
   end

   assign pos_sel  = pass_ff ? new_ff[axis_ff] : cur_ff[axis_ff];
   assign diff     = DIFF_W'(pos_sel) - pul_sel;
   assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   assign radicand = RAD_W'(acc_ff) << RAD_SHIFT;
   assign rt_start = (state_ff == S_RT_START);
   assign reel_in  = len_old_ff > len_new_ff;
   assign delta    = reel_in ? len_old_ff - len_new_ff : len_new_ff - len_old_ff;
   assign mag      = prod_ff[PROD_W-1:SCALE_SH];

   crsp_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (rt_start),
      .radicand (radicand),
      .done     (rt_done),
      .root     (rt_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         width_ff  <= CFG_DIM_W'(15840);
         depth_ff  <= CFG_DIM_W'(7280);
         height_ff <= CFG_DIM_W'(6400);
         spm_ff    <= SPM_W'(278142);
         cur_ff[0] <= '0;
         cur_ff[1] <= '0;
         cur_ff[2] <= '0;
         cable_ff  <= '0;
         pass_ff   <= 1'b0;
         axis_ff   <= '0;
         sat_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_FRAME_WIDTH:   width_ff  <= csr_wdata[CFG_DIM_W-1:0];
               REG_FRAME_DEPTH:   depth_ff  <= csr_wdata[CFG_DIM_W-1:0];
               REG_PULLEY_HEIGHT: height_ff <= csr_wdata[CFG_DIM_W-1:0];
               REG_STEPS_PER_MM:  spm_ff    <= csr_wdata;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  new_ff[0] <= req_tdata[17:0];
                  new_ff[1] <= req_tdata[35:18];
                  new_ff[2] <= req_tdata[53:36];
                  if (req_tuser == REQ_SET) begin
                     cur_ff[0] <= req_tdata[17:0];
                     cur_ff[1] <= req_tdata[35:18];
                     cur_ff[2] <= req_tdata[53:36];
                  end else begin
                     cable_ff <= '0;
                     pass_ff  <= 1'b0;
                     axis_ff  <= '0;
                     acc_ff   <= '0;
                     sat_ff   <= 1'b0;
                     state_ff <= S_SQ_OP;
                  end
               end
            end
            S_SQ_OP: begin
               mul_a_ff <= MUL_A_W'(diff_abs);
               mul_b_ff <= MUL_B_W'(diff_abs);
               state_ff <= S_SQ_MUL;
            end
            S_SQ_MUL: begin
               prod_ff  <= mul_a_ff * mul_b_ff;
               state_ff <= S_SQ_ACC;
            end
            S_SQ_ACC: begin
               acc_ff <= acc_ff + prod_ff[ACC_W-1:0];
               if (axis_ff == 2'd2) begin
                  axis_ff  <= '0;
                  state_ff <= S_RT_START;
               end else begin
                  axis_ff  <= axis_ff + 1'b1;
                  state_ff <= S_SQ_OP;
               end
            end
            S_RT_START: state_ff <= S_RT_WAIT;
            S_RT_WAIT: begin
               if (rt_done) begin
                  acc_ff <= '0;
                  if (pass_ff) begin
                     len_new_ff <= rt_root;
                     pass_ff    <= 1'b0;
                     state_ff   <= S_SC_OP;
                  end else begin
                     len_old_ff <= rt_root;
                     pass_ff    <= 1'b1;
                     state_ff   <= S_SQ_OP;
                  end
               end
            end
            S_SC_OP: begin
               mul_a_ff <= delta;
               mul_b_ff <= spm_ff;
               state_ff <= S_SC_MUL;
            end
            S_SC_MUL: begin
               prod_ff  <= mul_a_ff * mul_b_ff;
               state_ff <= S_SC_ACC;
            end
            S_SC_ACC: begin
               if (reel_in) begin
                  if (mag > STEP_MAX_MAG) begin
                     step_ff[cable_ff] <= STEP_MAX_MAG[STEP_W-1:0];
                     sat_ff <= 1'b1;
                  end else begin
                     step_ff[cable_ff] <= mag[STEP_W-1:0];
                  end
               end else begin
                  if (mag > STEP_MIN_MAG) begin
                     step_ff[cable_ff] <= STEP_W'(-STEP_MIN_MAG);
                     sat_ff <= 1'b1;
                  end else begin
                     step_ff[cable_ff] <= STEP_W'(-mag);
                  end
               end
               if (cable_ff == 2'(NUM_CABLES - 1)) begin
                  state_ff <= S_OUT;
               end else begin
                  cable_ff <= cable_ff + 1'b1;
                  state_ff <= S_SQ_OP;
               end
            end
            S_OUT: begin
               // commit the new position once the word is taken
               if (rsp_tready) begin
                  cur_ff[0] <= new_ff[0];
                  cur_ff[1] <= new_ff[1];
                  cur_ff[2] <= new_ff[2];
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {3'b000, sat_ff, step_ff[3], step_ff[2], step_ff[1], step_ff[0]};
endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Step planner check: positions and moves go in, per-cable step counts are
// predicted from cable lengths and compared word by word with the block.
// ----------------------------------------------------------------------------
module tb
   import crsp_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 20000;

   // lowest field in the lowest bits, as on rsp_tdata
   typedef struct packed {
      logic              sat;
      logic [STEP_W-1:0] c4, c3, c2, c1;
   } steps_type;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_tvalid = 0;
   logic              req_tready;
   logic [55:0]       req_tdata = '0;
   logic              req_tuser = 0;
   logic              rsp_tvalid;
   logic              rsp_tready = 0;
   logic [87:0]       rsp_tdata;
   logic              csr_we = 0;
   logic [1:0]        csr_addr = '0;
   logic [SPM_W-1:0]  csr_wdata = '0;

   // planner copy of the block's registers and position
   logic [16:0] frame_w, frame_d, pul_h;
   logic [23:0] spm;
   logic signed [COORD_W-1:0] cur_x, cur_y, cur_z;

   steps_type expected_steps[$];
   int     errors = 0;
   int     idle_cycles = 0;
   int     burst_left = 0;

   cable_robot_step_planner dut (.*);

   initial forever #5 clock = ~clock;

   // watchdog: cycles without any accepted word
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (($time / 4000) % 3 == 0) rsp_tready <= 1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      steps_type got, exp_s;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = steps_type'(rsp_tdata[84:0]);
         if (expected_steps.size() == 0) begin
            $display("%0t: unexpected word %h", $time, got);
            errors++;
         end else begin
            exp_s = expected_steps.pop_front();
            if (got.c1 !== exp_s.c1 || got.c2 !== exp_s.c2 || got.c3 !== exp_s.c3 ||
                got.c4 !== exp_s.c4 || got.sat !== exp_s.sat) begin
               $display("%0t: mismatch exp c1=%0d c2=%0d c3=%0d c4=%0d sat=%0b",
                        $time, $signed(exp_s.c1), $signed(exp_s.c2),
                        $signed(exp_s.c3), $signed(exp_s.c4), exp_s.sat);
               $display("%0t:          got c1=%0d c2=%0d c3=%0d c4=%0d sat=%0b",
                        $time, $signed(got.c1), $signed(got.c2),
                        $signed(got.c3), $signed(got.c4), got.sat);
               errors++;
            end
         end
      end
   end

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic logic [63:0] cable_len(longint px, longint py, longint pz,
                                            longint x, longint y, longint z);
      longint dx, dy, dz;
      logic [63:0] s;
      dx = x - px;
      dy = y - py;
      dz = z - pz;
      s = dx * dx + dy * dy + dz * dz;
      return int_sqrt(s << RAD_SHIFT);
   endfunction

   function automatic void plan_move(longint nx, longint ny, longint nz);
      longint px[4], py[4];
      logic [STEP_W-1:0] cnt[4];
      logic [63:0] lo, ln, delta;
      logic [127:0] mag;
      steps_type r;
      logic sat;
      px = '{0, 0, frame_w, frame_w};
      py = '{0, frame_d, frame_d, 0};
      sat = 0;
      for (int c = 0; c < 4; c++) begin
         lo = cable_len(px[c], py[c], pul_h, cur_x, cur_y, cur_z);
         ln = cable_len(px[c], py[c], pul_h, nx, ny, nz);
         delta = (lo > ln) ? lo - ln : ln - lo;
         mag = (128'(delta) * spm) >> SCALE_SH;
         if (lo > ln) begin
            if (mag > 1048575) begin mag = 1048575; sat = 1; end
            cnt[c] = mag[STEP_W-1:0];
         end else begin
            if (mag > 1048576) begin mag = 1048576; sat = 1; end
            cnt[c] = -mag[STEP_W-1:0];
         end
      end
      r.c1 = cnt[0]; r.c2 = cnt[1]; r.c3 = cnt[2]; r.c4 = cnt[3]; r.sat = sat;
      expected_steps.push_back(r);
   endfunction

   task automatic send_request(logic kind, logic signed [17:0] x, y, z);
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid = 1;
      req_tuser  = kind;
      req_tdata  = {2'b0, z, y, x};
      do @(posedge clock); while (!req_tready);
      if (kind == REQ_MOVE) plan_move(x, y, z);
      cur_x = x; cur_y = y; cur_z = z;
      @(negedge clock);
      req_tvalid = 0;
   endtask

   task automatic drain;
      while (expected_steps.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [23:0] val);
      csr_we = 1;
      csr_addr = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 0;
      case (idx)
         REG_FRAME_WIDTH:   frame_w = val[16:0];
         REG_FRAME_DEPTH:   frame_d = val[16:0];
         REG_PULLEY_HEIGHT: pul_h   = val[16:0];
         REG_STEPS_PER_MM:  spm     = val;
         default: ;
      endcase
   endtask

   function automatic logic signed [17:0] rand_coord(bit wide);
      if (wide) return 18'($urandom);
      return 18'($signed($urandom_range(0, 16000)) - 2000);
   endfunction

   task automatic test_directed;
      logic signed [17:0] ext[4];
      ext = '{-18'sd131072, 18'sd131071, 0, -1};
      send_request(REQ_MOVE, 0, 0, 0);          // equal lengths
      send_request(REQ_SET, 1600, 1600, 1600);  // no word
      send_request(REQ_MOVE, 8000, 3600, 800);
      foreach (ext[i]) send_request(REQ_MOVE, ext[i], ext[(i+1)%4], ext[(i+2)%4]);
      send_request(REQ_SET, -18'sd131072, -18'sd131072, -18'sd131072);
      send_request(REQ_MOVE, 18'sd131071, 18'sd131071, 18'sd131071); // corner to opposite corner
      send_request(REQ_MOVE, -18'sd131072, -18'sd131072, -18'sd131072);
      drain();
      write_reg(REG_STEPS_PER_MM, 24'hFFFFFF);
      send_request(REQ_MOVE, 100, 200, 300);
      send_request(REQ_MOVE, -100, 5000, -300);
      drain();
      write_reg(REG_STEPS_PER_MM, 0);           // all counts zero
      send_request(REQ_MOVE, 4000, 4000, 4000);
      drain();
   endtask

   task automatic test_random(int n, bit wide);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) < 7)
            send_request(REQ_MOVE, rand_coord(wide), rand_coord(wide), rand_coord(wide));
         else
            send_request(REQ_SET, rand_coord(wide), rand_coord(wide), rand_coord(wide));
      end
      drain();
   endtask

   task automatic test_configs;
      write_reg(REG_FRAME_WIDTH, 0);
      write_reg(REG_FRAME_DEPTH, 0);
      write_reg(REG_PULLEY_HEIGHT, 0);
      write_reg(REG_STEPS_PER_MM, 1);
      test_random(100, 1);
      write_reg(REG_FRAME_WIDTH, 17'h1FFFF);
      write_reg(REG_FRAME_DEPTH, 17'h1FFFF);
      write_reg(REG_PULLEY_HEIGHT, 17'h1FFFF);
      write_reg(REG_STEPS_PER_MM, 24'hFFFFFF);
      test_random(150, 1);
      write_reg(REG_FRAME_WIDTH, $urandom_range(0, 131071));
      write_reg(REG_FRAME_DEPTH, $urandom_range(0, 131071));
      write_reg(REG_PULLEY_HEIGHT, $urandom_range(0, 131071));
      write_reg(REG_STEPS_PER_MM, $urandom_range(1, 24'hFFFFFF));
      test_random(200, 1);
      write_reg(REG_FRAME_WIDTH, 15840);
      write_reg(REG_FRAME_DEPTH, 7280);
      write_reg(REG_PULLEY_HEIGHT, 6400);
      write_reg(REG_STEPS_PER_MM, 278142);
      test_random(400, 0);
      test_random(380, 1);
   endtask

   initial begin
      frame_w = 15840; frame_d = 7280; pul_h = 6400; spm = 278142;
      cur_x = 0; cur_y = 0; cur_z = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_configs();
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
